// ----- hdl/ipc_pkg.sv -----
// ----------------------------------------------------------------------------
// ipc_pkg
// Shared types and constants for the IP address text classifier.
// ----------------------------------------------------------------------------
package ipc_pkg;

  // ASCII codes the classifier cares about
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF    = 8'h66;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;

  // group and separator limits
  localparam int unsigned DEC_MAX_VAL   = 255;
  localparam int unsigned DEC_MAX_LEN   = 3;
  localparam int unsigned HEX_MAX_LEN   = 4;
  localparam int unsigned DOTS_NEEDED   = 3;
  localparam int unsigned COLONS_NEEDED = 7;

  // token queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = QPTR_W + 1;

  // character classes
  typedef enum logic [2:0] {
    CLS_DOT   = 3'd0,
    CLS_COLON = 3'd1,
    CLS_DEC   = 3'd2,
    CLS_HEX   = 3'd3,
    CLS_OTHER = 3'd4
  } char_cls_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_V4   = 2'd0,
    KIND_V6   = 2'd1,
    KIND_NONE = 2'd2
  } kind_t;

  // classified character word
  typedef struct packed {
    char_cls_t  cls;
    logic [3:0] digit;
    logic       last;
  } token_t;

endpackage

// ----- hdl/ipc_front.sv -----
// ----------------------------------------------------------------------------
// ipc_front
// Input side: classifies each character word into a token for the queue.
// ----------------------------------------------------------------------------
module ipc_front import ipc_pkg::*; (
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_byte,
  input  logic       in_is_last,
  output logic       push_valid,
  input  logic       push_ready,
  output token_t     push_tok
);

  // character class decode
  always_comb begin
    push_tok.digit = in_char_byte[3:0];
    push_tok.last  = in_is_last;
    if (in_char_byte == CHAR_DOT) begin
      push_tok.cls = CLS_DOT;
    end else if (in_char_byte == CHAR_COLON) begin
      push_tok.cls = CLS_COLON;
    end else if (in_char_byte >= CHAR_ZERO && in_char_byte <= CHAR_NINE) begin
      push_tok.cls = CLS_DEC;
    end else if ((in_char_byte >= CHAR_LA && in_char_byte <= CHAR_LF) ||
                 (in_char_byte >= CHAR_UA && in_char_byte <= CHAR_UF)) begin
      push_tok.cls = CLS_HEX;
    end else begin
      push_tok.cls = CLS_OTHER;
    end
  end

  // handshake passes straight to the queue
  assign push_valid = in_valid;
  assign in_stall   = !push_ready;

endmodule

// ----- hdl/ipc_queue.sv -----
// ----------------------------------------------------------------------------
// ipc_queue
// Small token FIFO decoupling the classifier from the state tracker.
// ----------------------------------------------------------------------------
module ipc_queue import ipc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_valid,
  output logic   push_ready,
  input  token_t push_tok,
  output logic   pop_valid,
  input  logic   pop,
  output token_t pop_tok
);

  token_t              tok_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_tok    = tok_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // pointer and fill update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      tok_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

// ----- hdl/ipc_back.sv -----
// ----------------------------------------------------------------------------
// ipc_back
// Tracks the dotted and colon readings per token and registers the verdict.
// ----------------------------------------------------------------------------
module ipc_back import ipc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       tok_valid,
  output logic       tok_pop,
  input  token_t     tok,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind
);

  logic       dotted_ok_r, dotted_ok_nxt;
  logic       colon_ok_r, colon_ok_nxt;
  logic [2:0] dot_count_r, dot_count_nxt;
  logic [3:0] colon_count_r, colon_count_nxt;
  logic [2:0] dec_len_r, dec_len_nxt;
  logic [9:0] dec_val_r, dec_val_nxt;
  logic       dec_lz_r, dec_lz_nxt;
  logic [2:0] hex_len_r, hex_len_nxt;
  logic       out_valid_r, out_valid_nxt;
  kind_t      out_kind_r, out_kind_nxt;
  logic       dec_good_cur, dec_good_new, hex_good_cur, hex_good_new;
  logic       v4, v6, emit;

  function automatic logic dec_good(logic [2:0] len, logic lz, logic [9:0] val);
    dec_good = (len >= 3'd1) && (len <= 3'(DEC_MAX_LEN)) &&
               !(lz && len > 3'd1) && (val <= 10'(DEC_MAX_VAL));
  endfunction

  function automatic logic hex_good(logic [2:0] len);
    hex_good = (len >= 3'd1) && (len <= 3'(HEX_MAX_LEN));
  endfunction

  // a last word needs the output slot; other words always drain
  assign tok_pop = tok_valid && (!tok.last || !out_valid_r || !out_stall);
  assign emit    = tok_pop && tok.last;

  assign dec_good_cur = dec_good(dec_len_r, dec_lz_r, dec_val_r);
  assign hex_good_cur = hex_good(hex_len_r);

  // per-character update of both readings
  always_comb begin
    dotted_ok_nxt   = dotted_ok_r;
    colon_ok_nxt    = colon_ok_r;
    dot_count_nxt   = dot_count_r;
    colon_count_nxt = colon_count_r;
    dec_len_nxt     = dec_len_r;
    dec_val_nxt     = dec_val_r;
    dec_lz_nxt      = dec_lz_r;
    hex_len_nxt     = hex_len_r;
    case (tok.cls)
      CLS_DOT: begin
        if (!dec_good_cur) dotted_ok_nxt = 1'b0;
        if (dot_count_r != 3'd7) dot_count_nxt = dot_count_r + 3'd1;
        dec_len_nxt  = '0;
        dec_val_nxt  = '0;
        dec_lz_nxt   = 1'b0;
        colon_ok_nxt = 1'b0;
      end
      CLS_COLON: begin
        if (!hex_good_cur) colon_ok_nxt = 1'b0;
        if (colon_count_r != 4'd15) colon_count_nxt = colon_count_r + 4'd1;
        hex_len_nxt   = '0;
        dotted_ok_nxt = 1'b0;
      end
      CLS_DEC: begin
        if (dec_len_r == '0 && tok.digit == 4'd0) dec_lz_nxt = 1'b1;
        // value stays below 100 here, so times ten plus a digit fits
        if (dec_len_r < 3'(DEC_MAX_LEN)) begin
          dec_val_nxt = {dec_val_r[6:0], 3'b000} + {dec_val_r[8:0], 1'b0} +
                        {6'd0, tok.digit};
        end
        if (dec_len_r != 3'd7) dec_len_nxt = dec_len_r + 3'd1;
        if (hex_len_r != 3'd7) hex_len_nxt = hex_len_r + 3'd1;
      end
      CLS_HEX: begin
        dotted_ok_nxt = 1'b0;
        if (hex_len_r != 3'd7) hex_len_nxt = hex_len_r + 3'd1;
      end
      default: begin
        dotted_ok_nxt = 1'b0;
        colon_ok_nxt  = 1'b0;
      end
    endcase
  end

  // verdict on the state after the final character
  assign dec_good_new = dec_good(dec_len_nxt, dec_lz_nxt, dec_val_nxt);
  assign hex_good_new = hex_good(hex_len_nxt);
  assign v4 = dotted_ok_nxt && (dot_count_nxt == 3'(DOTS_NEEDED)) && dec_good_new;
  assign v6 = colon_ok_nxt && (colon_count_nxt == 4'(COLONS_NEEDED)) && hex_good_new;

  // output register
  always_comb begin
    out_kind_nxt  = out_kind_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = v4 ? KIND_V4 : (v6 ? KIND_V6 : KIND_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || emit) begin
      dotted_ok_r   <= 1'b1;
      colon_ok_r    <= 1'b1;
      dot_count_r   <= '0;
      colon_count_r <= '0;
      dec_len_r     <= '0;
      dec_val_r     <= '0;
      dec_lz_r      <= 1'b0;
      hex_len_r     <= '0;
    end else if (tok_pop) begin
      dotted_ok_r   <= dotted_ok_nxt;
      colon_ok_r    <= colon_ok_nxt;
      dot_count_r   <= dot_count_nxt;
      colon_count_r <= colon_count_nxt;
      dec_len_r     <= dec_len_nxt;
      dec_val_r     <= dec_val_nxt;
      dec_lz_r      <= dec_lz_nxt;
      hex_len_r     <= hex_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;

`ifndef SYNTHESIS
  // a final word always lands in the output slot
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r)
    else $error("final word did not produce a result");

  // readings restart after every string
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (dotted_ok_r && colon_ok_r && dot_count_r == '0 &&
              colon_count_r == '0 && dec_len_r == '0 && hex_len_r == '0))
    else $error("state not cleared after final word");

  // a final word is never taken while an undelivered result is stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !emit)
    else $error("result overwritten while stalled");

  // counted group value stays within three digits
  a_dec_range: assert property (@(posedge clk) disable iff (!rst_n)
    dec_val_r <= 10'd999)
    else $error("decimal group value out of range");
`endif

endmodule

// ----- hdl/ip_address_text_classifier_unit.sv -----
// ----------------------------------------------------------------------------
// ip_address_text_classifier_unit
// Classifies an address string as IPv4, IPv6 or neither, one byte per word.
// ----------------------------------------------------------------------------
// Takes one character per cycle while in_stall is low, with in_is_last on
// the final byte; a kind word (0 IPv4, 1 IPv6, 2 neither) is registered once
// that byte has passed the four-entry token queue, which sits between the
// character classifier and the state tracker. The verdict sits in an output
// register, so a stalled result holds back only the next final byte while
// the queue keeps filling. No configuration, no clearing pass after reset.
module ip_address_text_classifier_unit import ipc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_byte,
  input  logic       in_is_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind
);

  logic   push_valid, push_ready;
  token_t push_tok;
  logic   pop_valid, pop;
  token_t pop_tok;

  ipc_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_byte (in_char_byte),
    .in_is_last   (in_is_last),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_tok     (push_tok)
  );

  ipc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_tok   (push_tok),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_tok    (pop_tok)
  );

  ipc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (pop_valid),
    .tok_pop   (pop),
    .tok       (pop_tok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_kind)
  );

endmodule
